// ----- hdl/mwr_pkg.sv -----
// Package for the multi-driver wire resolver.
// Holds the driver entry type, the sequencer states and the field widths.
// No dependencies.
`default_nettype none

package mwr_pkg;

  localparam int SlotW      = 3;
  localparam int StrengthW  = 3;
  localparam int ValueW     = 16;
  localparam int LevelW     = 15;
  localparam int InDataW    = 24;
  localparam int OutDataW   = 40;
  localparam int NumDriversDefault = 8;
  localparam logic [LevelW-1:0] LevelReset = 15'd3300;

  typedef struct packed {
    logic [StrengthW-1:0]     strength;
    logic                     mode;
    logic signed [ValueW-1:0] value;
  } drive_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  localparam logic MODE_DIGITAL = 1'b0;
  localparam logic MODE_ANALOG  = 1'b1;

endpackage

`default_nettype wire

// ----- hdl/multi_driver_wire_resolver_top.sv -----
// Top level of the multi-driver wire resolver: stream ports, sequencer,
// resolved-net registers and sensing. Uses mwr_pkg, mwr_table, mwr_resolve.
//
//   Channel   Direction  Handshake            Beat contents
//   s_*       in         s_tvalid / s_tready  one drive update for one slot
//   m_*       out        m_tvalid / m_tready  resolved net, change flag, sense
//   cfg_*     in         cfg_we               intrinsic level, 15 bits
//
// An update that changes a slot passes from input beat to result beat in
// these steps: the slot is read back, the driver table is read once per
// slot during the scan, the last read is drained and the result is loaded.
// The single table read port makes the scan read the slots one at a time.
// An update that changes nothing, or names a slot that does not exist, skips
// the scan. One update is in work at a time; a new input beat is taken
// as soon as the sequencer is idle, even while the previous result waits.
// A stalled result holds the sequencer in its final state.
// Reset (rst, synchronous) clears the table valid bits, the resolved net and
// the output valid flag, and sets the intrinsic level to 3300.
`default_nettype none

module multi_driver_wire_resolver_top #(
  parameter int NUM_DRIVERS = mwr_pkg::NumDriversDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  // Input beat, from bit 0: driver_slot[2:0], drive_strength[2:0],
  // drive_mode, drive_value[15:0], one zero pad bit.
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [mwr_pkg::InDataW-1:0]   s_tdata,
  // Result beat, from bit 0: wire_strength[2:0], wire_mode,
  // wire_value[15:0], wire_conflict, changed, sense_digital,
  // sense_analog[15:0], one zero pad bit.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [mwr_pkg::OutDataW-1:0]  m_tdata,
  input  logic                          cfg_we,
  input  logic [mwr_pkg::LevelW-1:0]    cfg_wdata
);

  localparam int IdxW = (NUM_DRIVERS > 1) ? $clog2(NUM_DRIVERS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_DRIVERS - 1);

  mwr_pkg::state_t state, state_next;

  // Configuration register.
  logic [mwr_pkg::LevelW-1:0] intrinsic_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      intrinsic_level <= mwr_pkg::LevelReset;
    end else if (cfg_we) begin
      intrinsic_level <= cfg_wdata;
    end
  end

  // Decode of the incoming beat. Digital values are normalized to 0 or 1
  // before they are compared or stored.
  logic [mwr_pkg::SlotW-1:0] in_slot;
  mwr_pkg::drive_t           in_drive;
  logic                      in_range;
  logic                      s_fire;

  always_comb begin
    in_slot           = s_tdata[2:0];
    in_drive.strength = s_tdata[5:3];
    in_drive.mode     = s_tdata[6];
    if (s_tdata[6] == mwr_pkg::MODE_ANALOG) begin
      in_drive.value = s_tdata[22:7];
    end else begin
      in_drive.value = (s_tdata[22:7] != '0) ? 16'sd1 : 16'sd0;
    end
    in_range = ({29'd0, in_slot} < NUM_DRIVERS);
  end

  assign s_tready = (state == mwr_pkg::ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;

  // Captured update.
  mwr_pkg::drive_t item_drive;
  logic [IdxW-1:0] item_idx;
  logic            item_range;

  always_ff @(posedge clk) begin
    if (s_fire) begin
      item_drive <= in_drive;
      item_idx   <= IdxW'(in_slot);
      item_range <= in_range;
    end
  end

  // Table access and scan control.
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  mwr_pkg::drive_t rd_data;
  logic            wr_en;
  logic [IdxW-1:0] scan_idx;
  logic [IdxW-1:0] scan_idx_next;
  logic            scan_pend;
  logic            upd;
  logic            upd_next;
  logic            res_clr;
  logic            out_load;
  logic            out_free;

  mwr_table #(
    .NUM_DRIVERS(NUM_DRIVERS)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (item_idx),
    .wr_data (item_drive)
  );

  mwr_pkg::drive_t best;
  logic            best_conflict;

  mwr_resolve u_resolve (
    .clk      (clk),
    .clr      (res_clr),
    .strobe   (scan_pend),
    .entry    (rd_data),
    .best     (best),
    .conflict (best_conflict)
  );

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next    = state;
    scan_idx_next = scan_idx;
    upd_next      = upd;
    rd_en         = 1'b0;
    rd_addr       = scan_idx;
    wr_en         = 1'b0;
    res_clr       = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      mwr_pkg::ST_IDLE: begin
        // Read the addressed slot back as the beat is taken.
        rd_addr = IdxW'(in_slot);
        if (s_fire) begin
          rd_en      = in_range;
          state_next = mwr_pkg::ST_CHECK;
        end
      end
      mwr_pkg::ST_CHECK: begin
        // The write lands before the scan's first read is issued.
        if (item_range && rd_data != item_drive) begin
          wr_en         = 1'b1;
          res_clr       = 1'b1;
          upd_next      = 1'b1;
          scan_idx_next = LastIdx;
          state_next    = mwr_pkg::ST_SCAN;
        end else begin
          upd_next   = 1'b0;
          state_next = mwr_pkg::ST_EMIT;
        end
      end
      mwr_pkg::ST_SCAN: begin
        rd_en = 1'b1;
        if (scan_idx == '0) begin
          state_next = mwr_pkg::ST_DRAIN;
        end else begin
          scan_idx_next = scan_idx - IdxW'(1);
        end
      end
      mwr_pkg::ST_DRAIN: begin
        state_next = mwr_pkg::ST_EMIT;
      end
      mwr_pkg::ST_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = mwr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mwr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mwr_pkg::ST_IDLE;
      scan_pend <= 1'b0;
      upd       <= 1'b0;
    end else begin
      state     <= state_next;
      scan_pend <= (state == mwr_pkg::ST_SCAN);
      upd       <= upd_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx <= scan_idx_next;
  end

  // Resolved net. On an update it takes the scan result; otherwise it holds.
  mwr_pkg::drive_t net;
  logic            net_conflict;
  mwr_pkg::drive_t net_new;
  logic            conflict_new;
  logic            changed;
  logic            sense_d;
  logic [mwr_pkg::ValueW-1:0] sense_a;
  logic signed [mwr_pkg::ValueW-1:0] half_level;

  always_comb begin
    net_new      = upd ? best : net;
    conflict_new = upd ? best_conflict : net_conflict;
    // Notify on a conflict change, on entering or leaving high impedance, or
    // on a mode or value change of a driven net. A strength change between
    // two driven strengths alone is not a change.
    changed = upd && ((best_conflict != net_conflict) ||
                      ((best.strength == '0) != (net.strength == '0)) ||
                      (best.strength != '0 &&
                       (best.mode != net.mode || best.value != net.value)));
    half_level = $signed({2'b00, intrinsic_level[mwr_pkg::LevelW-1:1]});
    if (net_new.mode == mwr_pkg::MODE_ANALOG) begin
      sense_d = (net_new.value >= half_level);
      sense_a = net_new.value;
    end else begin
      sense_d = (net_new.value != '0);
      sense_a = (net_new.value != '0) ? {1'b0, intrinsic_level} : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      net          <= '0;
      net_conflict <= 1'b0;
    end else if (out_load) begin
      net          <= net_new;
      net_conflict <= conflict_new;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {1'b0, sense_a, sense_d, changed, conflict_new,
                  net_new.value, net_new.mode, net_new.strength};
    end
  end

endmodule

`default_nettype wire

// ----- hdl/mwr_table.sv -----
// Driver table: one synchronous memory entry per driver slot, registered read.
// Per-entry valid bits make unwritten slots read as an idle driver after reset.
// Depends on mwr_pkg.
`default_nettype none

module mwr_table #(
  parameter int NUM_DRIVERS = mwr_pkg::NumDriversDefault,
  localparam int IdxW = (NUM_DRIVERS > 1) ? $clog2(NUM_DRIVERS) : 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            rd_en,
  input  logic [IdxW-1:0] rd_addr,
  output mwr_pkg::drive_t rd_data,
  input  logic            wr_en,
  input  logic [IdxW-1:0] wr_addr,
  input  mwr_pkg::drive_t wr_data
);

  mwr_pkg::drive_t        mem [NUM_DRIVERS];
  logic [NUM_DRIVERS-1:0] valid;
  mwr_pkg::drive_t        rd_raw;
  logic                   rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_valid ? rd_raw : '0;

endmodule

`default_nettype wire

// ----- hdl/mwr_resolve.sv -----
// Resolution accumulator: takes driver entries from the highest slot down and
// keeps the winning drive and the conflict flag. Depends on mwr_pkg.
`default_nettype none

module mwr_resolve (
  input  logic            clk,
  input  logic            clr,
  input  logic            strobe,
  input  mwr_pkg::drive_t entry,
  output mwr_pkg::drive_t best,
  output logic            conflict
);

  always_ff @(posedge clk) begin
    if (clr) begin
      best     <= '0;
      conflict <= 1'b0;
    end else if (strobe && entry.strength != '0) begin
      if (entry.strength > best.strength) begin
        best     <= entry;
        conflict <= 1'b0;
      end else if (entry.strength == best.strength) begin
        if (entry.mode != best.mode || entry.value != best.value) begin
          conflict <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/mwr_checker.sv -----
// Port-level checker for the multi-driver wire resolver, with its bind.
// Depends on mwr_pkg and multi_driver_wire_resolver_top.
`default_nettype none

module mwr_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [mwr_pkg::OutDataW-1:0] m_tdata
);

  // A stalled result beat holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // No result beat is shown right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result beat valid after reset");

  // One update at a time: the input closes after a beat is taken.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an update is in work");

  // A high-impedance net is digital zero with no conflict and zero sense.
  a_hiz: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] == 3'd0 |->
      m_tdata[20:3] == '0 && m_tdata[39:22] == '0)
    else $error("high-impedance net with nonzero fields");

  // A digital net carries a normalized value.
  a_digital: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[3] |-> m_tdata[19:5] == '0 && m_tdata[39] == 1'b0)
    else $error("digital net value not normalized");

endmodule

bind multi_driver_wire_resolver_top mwr_checker u_mwr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
